### rtl/core/fdch_pkg.sv
// Shared types and constants for the fan duty curve unit.
`default_nettype none

package fdch_pkg;

  // Register index field of the configuration port
  localparam int CfgIdxBits = 3;

  // Register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TEMP_START  = 3'd0,
    CFG_TEMP_FULL   = 3'd1,
    CFG_HYSTERESIS  = 3'd2,
    CFG_MIN_DUTY    = 3'd3,
    CFG_MAX_DUTY    = 3'd4,
    CFG_UPDATE_TOL  = 3'd5,
    CFG_MANUAL_OVR  = 3'd6
  } cfg_idx_e;

  // Fixed field widths
  localparam int HystBits = 12;
  localparam int PctBits  = 7;

  // Percentage limit
  localparam logic [PctBits-1:0] PctFull = 7'd100;

  // Reset values of the registers
  localparam int TempStartRst = 640;
  localparam int TempFullRst  = 960;
  localparam int HystRst      = 32;
  localparam int MinDutyRst   = 300;
  localparam int MaxDutyRst   = 1023;
  localparam int UpdTolRst    = 10;

endpackage

`default_nettype wire

### rtl/core/fan_duty_curve_with_hysteresis_unit.sv
// Fan duty curve with hysteresis: bit-serial ramp multiply and divide, duty percentage.
// A ramp request runs TEMP_BITS-1 shift-add multiply steps and DUTY_BITS restoring divide
// steps; the percentage takes up to 7 more divide steps on the same shared divider.
// One request in flight at a time; the next is taken the cycle after the result enters the
// output register, which waits while the output is stalled. Reset (async, active low) loads
// defaults, fan off.
`default_nettype none

module fan_duty_curve_with_hysteresis_unit #(
  parameter int DUTY_BITS = 10,
  parameter int TEMP_BITS = 16,
  localparam int TrBits   = TEMP_BITS - 1,
  localparam int CfgBits  = (TrBits > fdch_pkg::HystBits)
                            ? ((TrBits > DUTY_BITS) ? TrBits : DUTY_BITS)
                            : ((fdch_pkg::HystBits > DUTY_BITS) ? fdch_pkg::HystBits
                                                                : DUTY_BITS)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration writes
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [fdch_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire  [CfgBits-1:0]                 cfg_data_i,
  // sample requests
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  signed [TEMP_BITS-1:0]        temperature_i,
  input  wire                                sensor_fault_i,
  // results
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [DUTY_BITS-1:0]               fan_duty_o,
  output logic [fdch_pkg::PctBits-1:0]       duty_percent_o,
  output logic                               duty_changed_o,
  output logic                               sensor_error_o
);

  localparam int DivBits = (TrBits > DUTY_BITS) ? TrBits : DUTY_BITS;
  localparam int ProdBits = DivBits + DUTY_BITS;
  localparam int QuoBits = (DUTY_BITS > fdch_pkg::PctBits) ? DUTY_BITS : fdch_pkg::PctBits;
  localparam int TgtBits = DUTY_BITS + 2;
  localparam int DltBits = DUTY_BITS + 3;
  localparam int CmpBits = ((TEMP_BITS > fdch_pkg::HystBits + 1) ? TEMP_BITS
                                                                 : fdch_pkg::HystBits + 1) + 1;
  localparam int StepMax = (DivBits > fdch_pkg::PctBits) ? DivBits : fdch_pkg::PctBits;
  localparam int CntBits = $clog2(StepMax + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_RAMP,
    ST_APPLY,
    ST_PCT,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [TrBits-1:0]             temp_start_q;
  logic [TrBits-1:0]             temp_full_q;
  logic [fdch_pkg::HystBits-1:0] hyst_q;
  logic [DUTY_BITS-1:0]          min_duty_q;
  logic [DUTY_BITS-1:0]          max_duty_q;
  logic [DUTY_BITS-1:0]          upd_tol_q;
  logic                          manual_ovr_q;

  // duty state and request
  logic [DUTY_BITS-1:0]          cur_duty_q;
  logic signed [TEMP_BITS-1:0]   temp_q;
  logic                          fault_q;
  logic                          err_q;
  logic                          changed_q;
  logic                          neg_q;
  logic                          pct_mode_q;
  logic signed [TgtBits-1:0]     target_q;
  logic [fdch_pkg::PctBits-1:0]  pct_res_q;

  // serial datapath
  logic [ProdBits-1:0]           rem_q;
  logic [ProdBits-1:0]           mcand_q;
  logic [ProdBits-1:0]           sdiv_q;
  logic [TrBits-1:0]             mplier_q;
  logic [QuoBits-1:0]            quo_q;
  logic [CntBits-1:0]            cnt_q;

  // output register
  logic                          out_valid_q;
  logic [DUTY_BITS-1:0]          fan_duty_q;
  logic [fdch_pkg::PctBits-1:0]  pct_q;
  logic                          out_changed_q;
  logic                          out_err_q;

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign fan_duty_o     = fan_duty_q;
  assign duty_percent_o = pct_q;
  assign duty_changed_o = out_changed_q;
  assign sensor_error_o = out_err_q;

  // decision compares on the held sample
  logic signed [CmpBits-1:0] temp_x;
  logic signed [CmpBits-1:0] off_x;
  logic                      below_off;
  logic                      at_full;
  logic                      at_start;
  logic                      duty_neg;
  logic [DUTY_BITS-1:0]      duty_mag;
  logic [TrBits-1:0]         temp_ofs;
  logic [TrBits-1:0]         ramp_range;

  assign temp_x     = CmpBits'(temp_q);
  assign off_x      = $signed(CmpBits'(temp_start_q)) - $signed(CmpBits'(hyst_q));
  assign below_off  = (temp_x < off_x);
  assign at_full    = (temp_q[TrBits-1:0] >= temp_full_q);
  assign at_start   = (temp_q[TrBits-1:0] >= temp_start_q);
  assign duty_neg   = (max_duty_q < min_duty_q);
  assign duty_mag   = duty_neg ? (min_duty_q - max_duty_q) : (max_duty_q - min_duty_q);
  assign temp_ofs   = temp_q[TrBits-1:0] - temp_start_q;
  assign ramp_range = temp_full_q - temp_start_q;

  // one shift-add step and one restoring divide step
  logic [ProdBits-1:0] acc_d;
  logic                div_ge;
  logic [ProdBits-1:0] rem_sub;
  logic [QuoBits-1:0]  quo_d;

  assign acc_d   = rem_q + (mplier_q[0] ? mcand_q : '0);
  assign div_ge  = (rem_q >= sdiv_q);
  assign rem_sub = rem_q - sdiv_q;
  assign quo_d   = {quo_q[QuoBits-2:0], div_ge};

  // ramp target from the quotient
  logic signed [TgtBits-1:0] quo_x;
  logic signed [TgtBits-1:0] ramp_tgt;

  assign quo_x    = $signed(TgtBits'(quo_q[DUTY_BITS-1:0]));
  assign ramp_tgt = $signed(TgtBits'(min_duty_q)) + (neg_q ? -quo_x : quo_x);

  // apply rule
  logic signed [DltBits-1:0] cur_x;
  logic signed [DltBits-1:0] max_x;
  logic signed [DltBits-1:0] tgt_x;
  logic signed [DltBits-1:0] dlt;
  logic [DltBits-1:0]        dlt_abs;
  logic                      take;
  logic [DUTY_BITS-1:0]      clamp_d;
  logic [DUTY_BITS-1:0]      cur_d;

  assign cur_x   = $signed(DltBits'(cur_duty_q));
  assign max_x   = $signed(DltBits'(max_duty_q));
  assign tgt_x   = DltBits'(target_q);
  assign dlt     = tgt_x - cur_x;
  assign dlt_abs = dlt[DltBits-1] ? DltBits'(-dlt) : DltBits'(dlt);
  assign take    = (dlt_abs >= DltBits'(upd_tol_q)) || (tgt_x == '0) ||
                   (tgt_x == max_x) || err_q;

  always_comb begin
    if (tgt_x < $signed(DltBits'(0))) begin
      clamp_d = '0;
    end else if (tgt_x > max_x) begin
      clamp_d = max_duty_q;
    end else begin
      clamp_d = target_q[DUTY_BITS-1:0];
    end
    cur_d = (take && (tgt_x != cur_x)) ? clamp_d : cur_duty_q;
  end

  // duty times 100 as shifts
  logic [ProdBits-1:0] cur_p;
  logic [ProdBits-1:0] pct_num;

  assign cur_p   = ProdBits'(cur_duty_q);
  assign pct_num = (cur_p << 6) + (cur_p << 5) + (cur_p << 2);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_start_q <= TrBits'(fdch_pkg::TempStartRst);
      temp_full_q  <= TrBits'(fdch_pkg::TempFullRst);
      hyst_q       <= fdch_pkg::HystBits'(fdch_pkg::HystRst);
      min_duty_q   <= DUTY_BITS'(fdch_pkg::MinDutyRst);
      max_duty_q   <= DUTY_BITS'(fdch_pkg::MaxDutyRst);
      upd_tol_q    <= DUTY_BITS'(fdch_pkg::UpdTolRst);
      manual_ovr_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fdch_pkg::CFG_TEMP_START: temp_start_q <= cfg_data_i[TrBits-1:0];
        fdch_pkg::CFG_TEMP_FULL:  temp_full_q  <= cfg_data_i[TrBits-1:0];
        fdch_pkg::CFG_HYSTERESIS: hyst_q       <= cfg_data_i[fdch_pkg::HystBits-1:0];
        fdch_pkg::CFG_MIN_DUTY:   min_duty_q   <= cfg_data_i[DUTY_BITS-1:0];
        fdch_pkg::CFG_MAX_DUTY:   max_duty_q   <= cfg_data_i[DUTY_BITS-1:0];
        fdch_pkg::CFG_UPDATE_TOL: upd_tol_q    <= cfg_data_i[DUTY_BITS-1:0];
        fdch_pkg::CFG_MANUAL_OVR: manual_ovr_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer, serial datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cur_duty_q    <= '0;
      out_valid_q   <= 1'b0;
      temp_q        <= '0;
      fault_q       <= 1'b0;
      err_q         <= 1'b0;
      changed_q     <= 1'b0;
      neg_q         <= 1'b0;
      pct_mode_q    <= 1'b0;
      target_q      <= '0;
      pct_res_q     <= '0;
      rem_q         <= '0;
      mcand_q       <= '0;
      sdiv_q        <= '0;
      mplier_q      <= '0;
      quo_q         <= '0;
      cnt_q         <= '0;
      fan_duty_q    <= '0;
      pct_q         <= '0;
      out_changed_q <= 1'b0;
      out_err_q     <= 1'b0;
    end else begin
      // result leaves
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            temp_q  <= temperature_i;
            fault_q <= sensor_fault_i;
            state_q <= ST_DECIDE;
          end
        end

        // pick the duty request
        ST_DECIDE: begin
          err_q <= 1'b0;
          state_q <= ST_APPLY;
          if (manual_ovr_q) begin
            target_q <= $signed(TgtBits'(max_duty_q));
          end else if (fault_q || temp_q[TEMP_BITS-1]) begin
            target_q <= $signed(TgtBits'(max_duty_q));
            err_q    <= 1'b1;
          end else if (below_off) begin
            target_q <= '0;
          end else if (at_full) begin
            target_q <= $signed(TgtBits'(max_duty_q));
          end else if (at_start) begin
            neg_q      <= duty_neg;
            mplier_q   <= temp_ofs;
            mcand_q    <= ProdBits'(duty_mag);
            rem_q      <= '0;
            sdiv_q     <= ProdBits'(ramp_range) << (DUTY_BITS - 1);
            quo_q      <= '0;
            cnt_q      <= CntBits'(TrBits);
            pct_mode_q <= 1'b0;
            state_q    <= ST_MUL;
          end else begin
            target_q <= $signed(TgtBits'(cur_duty_q));
          end
        end

        // offset times duty span, one multiplier bit a cycle
        ST_MUL: begin
          rem_q    <= acc_d;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            cnt_q   <= CntBits'(DUTY_BITS);
            state_q <= ST_DIV;
          end
        end

        // shared restoring divider, one quotient bit a cycle
        ST_DIV: begin
          if (div_ge) begin
            rem_q <= rem_sub;
          end
          quo_q  <= quo_d;
          sdiv_q <= sdiv_q >> 1;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            if (pct_mode_q) begin
              pct_res_q <= quo_d[fdch_pkg::PctBits-1:0];
              state_q   <= ST_DONE;
            end else begin
              state_q <= ST_RAMP;
            end
          end
        end

        ST_RAMP: begin
          target_q <= ramp_tgt;
          state_q  <= ST_APPLY;
        end

        // tolerance check and clamp
        ST_APPLY: begin
          cur_duty_q <= cur_d;
          changed_q  <= (cur_d != cur_duty_q);
          state_q    <= ST_PCT;
        end

        // percentage: trivial cases direct, else divide
        ST_PCT: begin
          if (cur_duty_q == '0) begin
            pct_res_q <= '0;
            state_q   <= ST_DONE;
          end else if (cur_duty_q >= max_duty_q) begin
            pct_res_q <= fdch_pkg::PctFull;
            state_q   <= ST_DONE;
          end else begin
            rem_q      <= pct_num;
            sdiv_q     <= ProdBits'(max_duty_q) << (fdch_pkg::PctBits - 1);
            quo_q      <= '0;
            cnt_q      <= CntBits'(fdch_pkg::PctBits);
            pct_mode_q <= 1'b1;
            state_q    <= ST_DIV;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            fan_duty_q    <= cur_duty_q;
            pct_q         <= pct_res_q;
            out_changed_q <= changed_q;
            out_err_q     <= err_q;
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
